### hdl/vdh_pkg.sv
`timescale 1ns / 1ps

package vdh_pkg;

    // Store geometry
    localparam int ROW_COUNT = 512;
    localparam int BIN_COUNT = 256;
    localparam int DEPTH     = ROW_COUNT * BIN_COUNT;
    localparam int ADDR_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    // Field widths
    localparam int ACTION_W  = 2;
    localparam int ROW_W     = 9;
    localparam int DISP_W    = 8;
    localparam int COUNT_W   = 8;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_W     = 8;

    localparam logic [COUNT_W-1:0] COUNT_MAX   = 8'd255;
    localparam logic [CFG_W-1:0]   LOWER_RESET = 8'd0;
    localparam logic [CFG_W-1:0]   UPPER_RESET = 8'd225;

    typedef enum logic [ACTION_W-1:0] {
        ACT_CLEAR = 2'd0,
        ACT_ACCUM = 2'd1,
        ACT_READ  = 2'd2
    } t_action;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_LOWER = 1'b0,
        REG_UPPER = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC_RD,
        S_ACC_WR,
        S_RD_MEM,
        S_RD_OUT
    } t_state;

    typedef struct packed {
        logic load_item;
        logic mem_rd;
        logic mem_inc;
        logic clr_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic acc_hit;
        logic clr_last;
        logic out_free;
    } t_status;

endpackage

### hdl/vdh_if.sv
`timescale 1ns / 1ps

interface vdh_item_if;
    logic                        valid;
    logic                        ready;
    logic [vdh_pkg::ACTION_W-1:0] action;
    logic [vdh_pkg::ROW_W-1:0]    row_index;
    logic [vdh_pkg::DISP_W-1:0]   disparity;

    modport source (output valid, output action, output row_index, output disparity,
                    input ready);
    modport sink   (input valid, input action, input row_index, input disparity,
                    output ready);
endinterface

interface vdh_result_if;
    logic                        valid;
    logic                        ready;
    logic [vdh_pkg::COUNT_W-1:0] bin_count;

    modport source (output valid, output bin_count, input ready);
    modport sink   (input valid, input bin_count, output ready);
endinterface

interface vdh_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [vdh_pkg::CFG_IDX_W-1:0] index;
    logic [vdh_pkg::CFG_W-1:0]     data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/v_disparity_histogram_top.sv
`timescale 1ns / 1ps

// V-disparity histogram: one 8-bit saturating counter per (row, disparity bin),
// held in a single-port memory of ROW_COUNT x BIN_COUNT entries (131072 here).
// After reset, and after every clear item, the block sweeps the whole memory to
// zero at one entry per cycle and takes no item meanwhile; configuration
// writes are taken at any time. An accumulate that hits a bin passes through
// accept, memory read and write back; one that is filtered out or falls outside
// the store ends at acceptance. A read passes through accept, memory read and
// the load of its result register, which waits until the previous result has
// been transferred; the next item is accepted while a result waits. The
// read-then-write on the one memory port sets the accumulate rate.
module v_disparity_histogram_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    vdh_item_if.sink     i_item,
    vdh_result_if.source o_result,
    vdh_cfg_if.sink      i_cfg
);

    vdh_pkg::t_cmd    cmd;
    vdh_pkg::t_status status;

    assign i_cfg.ready = 1'b1;

    vdh_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (i_item.valid),
        .i_item_action (i_item.action),
        .o_item_ready  (i_item.ready),
        .i_status      (status),
        .o_cmd         (cmd)
    );

    vdh_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_row_index (i_item.row_index),
        .i_disparity (i_item.disparity),
        .i_cfg_we    (i_cfg.valid),
        .i_cfg_index (i_cfg.index),
        .i_cfg_data  (i_cfg.data),
        .i_out_ready (o_result.ready),
        .o_out_valid (o_result.valid),
        .o_out_count (o_result.bin_count),
        .i_cmd       (cmd),
        .o_status    (status)
    );

    a_no_item_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_step |-> !i_item.ready)
        else $error("item port open during clearing sweep");

    a_inc_after_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.mem_inc |-> $past(cmd.mem_rd))
        else $error("write back without a preceding memory read");

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_result.valid || o_result.ready))
        else $error("result register overwritten before transfer");

    a_single_mem_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(cmd.mem_inc && (cmd.mem_rd || cmd.clr_step)))
        else $error("conflicting memory operations");

endmodule

### hdl/vdh_ctrl.sv
`timescale 1ns / 1ps

module vdh_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_item_valid,
    input  logic [vdh_pkg::ACTION_W-1:0] i_item_action,
    output logic                         o_item_ready,
    input  vdh_pkg::t_status             i_status,
    output vdh_pkg::t_cmd                o_cmd
);

    vdh_pkg::t_state r_state;
    vdh_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= vdh_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_cmd        = '0;
        o_item_ready = 1'b0;
        case (r_state)
            vdh_pkg::S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_status.clr_last) begin
                    n_state = vdh_pkg::S_IDLE;
                end
            end
            vdh_pkg::S_IDLE: begin
                o_item_ready = 1'b1;
                if (i_item_valid) begin
                    o_cmd.load_item = 1'b1;
                    case (i_item_action)
                        vdh_pkg::ACT_CLEAR: n_state = vdh_pkg::S_CLEAR;
                        vdh_pkg::ACT_ACCUM: begin
                            if (i_status.acc_hit) begin
                                n_state = vdh_pkg::S_ACC_RD;
                            end
                        end
                        vdh_pkg::ACT_READ:  n_state = vdh_pkg::S_RD_MEM;
                        default:            n_state = vdh_pkg::S_IDLE;
                    endcase
                end
            end
            vdh_pkg::S_ACC_RD: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = vdh_pkg::S_ACC_WR;
            end
            vdh_pkg::S_ACC_WR: begin
                o_cmd.mem_inc = 1'b1;
                n_state       = vdh_pkg::S_IDLE;
            end
            vdh_pkg::S_RD_MEM: begin
                o_cmd.mem_rd = 1'b1;
                n_state      = vdh_pkg::S_RD_OUT;
            end
            vdh_pkg::S_RD_OUT: begin
                // hold until the previous result has been transferred
                if (i_status.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = vdh_pkg::S_IDLE;
                end
            end
            default: n_state = vdh_pkg::S_IDLE;
        endcase
    end

endmodule

### hdl/vdh_datapath.sv
`timescale 1ns / 1ps

module vdh_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [vdh_pkg::ROW_W-1:0]     i_row_index,
    input  logic [vdh_pkg::DISP_W-1:0]    i_disparity,
    input  logic                          i_cfg_we,
    input  logic [vdh_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [vdh_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                          i_out_ready,
    output logic                          o_out_valid,
    output logic [vdh_pkg::COUNT_W-1:0]   o_out_count,
    input  vdh_pkg::t_cmd                 i_cmd,
    output vdh_pkg::t_status              o_status
);

    localparam int ADDR_W = vdh_pkg::ADDR_W;
    localparam int CW     = vdh_pkg::COUNT_W;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(vdh_pkg::DEPTH - 1);
    localparam logic [ADDR_W-1:0] BINS_A    = ADDR_W'(vdh_pkg::BIN_COUNT);

    logic [CW-1:0] r_mem [vdh_pkg::DEPTH];

    logic [vdh_pkg::CFG_W-1:0] r_lower;
    logic [vdh_pkg::CFG_W-1:0] r_upper;
    logic [ADDR_W-1:0]         r_clr_addr;
    logic [ADDR_W-1:0]         r_addr;
    logic                      r_in_range;
    logic [CW-1:0]             r_rd_data;
    logic                      r_out_valid;
    logic [CW-1:0]             r_out_count;

    logic [ADDR_W-1:0] n_addr;
    logic              n_in_range;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic [CW-1:0]     wr_data;
    logic [CW-1:0]     inc_data;

    // row-major: row * BIN_COUNT + bin, only meaningful when in range
    assign n_in_range = (32'(i_row_index) < vdh_pkg::ROW_COUNT)
                     && (32'(i_disparity) < vdh_pkg::BIN_COUNT);
    assign n_addr     = ADDR_W'(ADDR_W'(i_row_index) * BINS_A) + ADDR_W'(i_disparity);

    assign o_status.acc_hit  = n_in_range && (i_disparity > r_lower)
                            && (i_disparity < r_upper);
    assign o_status.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_status.out_free = !r_out_valid || i_out_ready;

    assign inc_data = (r_rd_data == vdh_pkg::COUNT_MAX) ? r_rd_data : r_rd_data + 1'b1;
    assign mem_we   = i_cmd.clr_step || i_cmd.mem_inc;
    assign wr_addr  = i_cmd.clr_step ? r_clr_addr : r_addr;
    assign wr_data  = i_cmd.clr_step ? '0 : inc_data;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_cmd.mem_rd && r_in_range) begin
            r_rd_data <= r_mem[r_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_item) begin
            r_addr     <= n_addr;
            r_in_range <= n_in_range;
        end
        if (i_cmd.out_load) begin
            r_out_count <= r_in_range ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lower     <= vdh_pkg::LOWER_RESET;
            r_upper     <= vdh_pkg::UPPER_RESET;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (vdh_pkg::t_cfg_reg'(i_cfg_index))
                    vdh_pkg::REG_LOWER: r_lower <= i_cfg_data;
                    vdh_pkg::REG_UPPER: r_upper <= i_cfg_data;
                    default: ;
                endcase
            end
            // sweep counter wraps so the next clear starts at zero
            if (i_cmd.clr_step) begin
                r_clr_addr <= o_status.clr_last ? '0 : r_clr_addr + 1'b1;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_count = r_out_count;

endmodule
